### rtl/pkh_pkg.sv
// shared types, constants and crc function for the packet header generator
`timescale 1ns / 1ps

package pkh_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned HDR_LEN  = 4;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned APB_W    = 32;

    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;
    localparam logic [BYTE_W-1:0] ID_RESET  = 8'h00;

    // register word indexes
    typedef enum logic [0:0] {
        REG_PACKET_ID = 1'b0,
        REG_NONE      = 1'b1
    } reg_index_t;

    // header load request from the crc side to the serialiser
    typedef struct packed {
        logic              load;
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] id;
    } hdr_load_t;

    // serialiser status back to the input side
    typedef struct packed {
        logic can_load;
        logic busy;
    } hdr_status_t;

    // msb-first crc-16 update over one byte
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/pkh_cfg.sv
// apb configuration register for the packet id
`timescale 1ns / 1ps

module pkh_cfg
    import pkh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output logic [BYTE_W-1:0] packet_id
);

    logic [BYTE_W-1:0] id_reg;
    logic [BYTE_W-1:0] id_next;
    reg_index_t        index;
    logic              wr_en;

    // word index from the byte address
    assign index  = reg_index_t'(paddr[ADDR_W-1]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register write decode
    always_comb
    begin
        id_next = id_reg;
        if (wr_en && (index == REG_PACKET_ID))
            id_next = pwdata[BYTE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            id_reg <= ID_RESET;
        else
            id_reg <= id_next;
    end

    // read mux
    always_comb
    begin
        case (index)
            REG_PACKET_ID: prdata = {{(APB_W-BYTE_W){1'b0}}, id_reg};
            default:       prdata = '0;
        endcase
    end

    assign packet_id = id_reg;

endmodule

### rtl/pkh_crc.sv
// running crc accumulator, one byte per cycle while accept is high
`timescale 1ns / 1ps

module pkh_crc
    import pkh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    input  logic [BYTE_W-1:0] packet_id,
    output hdr_load_t         hdr_load
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] crc_fold_val;

    // fold the incoming byte into the running crc
    assign crc_fold_val = crc_fold(crc_reg, data_byte);

    always_comb
    begin
        crc_next = crc_reg;
        if (accept)
            crc_next = last_byte ? CRC_INIT : crc_fold_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    // header request on the final byte
    assign hdr_load.load = accept && last_byte;
    assign hdr_load.crc  = crc_fold_val;
    assign hdr_load.id   = packet_id;

    // crc reloads after the final byte
    a_crc_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (crc_reg == CRC_INIT))
        else $error("crc not reloaded after final byte");

endmodule

### rtl/pkh_hdr.sv
// header serialiser: lrc, id, crc low, crc high
`timescale 1ns / 1ps

module pkh_hdr
    import pkh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  hdr_load_t         hdr_load,
    output hdr_status_t       status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast
);

    logic [HDR_LEN*BYTE_W-1:0] shift_reg;
    logic [HDR_LEN*BYTE_W-1:0] shift_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      pop;
    logic [BYTE_W-1:0]         sum;
    logic [BYTE_W-1:0]         lrc;

    assign pop = m_tvalid && m_tready;

    // load allowed when empty or the last word leaves this cycle
    assign status.can_load = (count_reg == '0) || ((count_reg == CNT_W'(1)) && m_tready);
    assign status.busy     = (count_reg != '0);

    // lrc is the negated byte sum of id and crc bytes
    assign sum = hdr_load.id + hdr_load.crc[BYTE_W-1:0] + hdr_load.crc[CRC_W-1:BYTE_W];
    assign lrc = (sum ^ BYTE_MASK) + BYTE_W'(1);

    always_comb
    begin
        shift_next = shift_reg;
        count_next = count_reg;
        if (pop)
        begin
            shift_next = {{BYTE_W{1'b0}}, shift_reg[HDR_LEN*BYTE_W-1:BYTE_W]};
            count_next = count_reg - CNT_W'(1);
        end
        if (hdr_load.load)
        begin
            shift_next = {hdr_load.crc[CRC_W-1:BYTE_W], hdr_load.crc[BYTE_W-1:0],
                          hdr_load.id, lrc};
            count_next = CNT_W'(HDR_LEN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    // output word
    assign m_tvalid = status.busy;
    assign m_tdata  = shift_reg[BYTE_W-1:0];
    assign m_tlast  = (count_reg == CNT_W'(1));

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HDR_LEN))
        else $error("header count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_load.load |-> ((count_reg == '0) || ((count_reg == CNT_W'(1)) && pop)))
        else $error("header overwritten before sent");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !hdr_load.load) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("header count did not step");

endmodule

### rtl/packet_header_crc16_lrc.sv
// top level of the packet header generator
`timescale 1ns / 1ps

// Packet header generator: CRC-16/CCITT-FALSE plus LRC header.
// Input stream s_*: one payload byte per word in s_tdata, s_tlast on the
// final byte of a packet. Each byte is folded into the running CRC in the
// cycle it is accepted, so non-final payload bytes are taken every cycle.
// Output stream m_*: on the final byte, four header words follow from the
// cycle after acceptance: LRC, packet ID, CRC low, CRC high; m_tlast marks
// the fourth.
// Throughput is one payload byte per cycle; a final byte waits (s_tready
// low) while a previous header still has words to send, unless only its
// last word is left and leaves in that cycle. This is set by the single
// four-byte header buffer. Packets of four or more bytes therefore run
// without pause when the receiver is ready.
// Receiver stall: header words hold on m_tdata; non-final bytes are still
// taken, final bytes wait for the header buffer.
// APB: register packet_id at byte address 0, written on psel, penable,
// pwrite high; pready is always high. The ID is sampled with the final byte.
// Reset: CRC reloads to 0xFFFF, packet_id clears, header buffer empties.

module packet_header_crc16_lrc
    import pkh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // slave stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,
    // master stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] header_byte
    output logic              m_tlast,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    logic [BYTE_W-1:0] packet_id;
    hdr_load_t         hdr_load;
    hdr_status_t       hdr_status;
    logic              accept;

    // final byte waits for room in the header buffer
    assign s_tready = !s_tlast || hdr_status.can_load;
    assign accept   = s_tvalid && s_tready;

    pkh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .packet_id (packet_id)
    );

    pkh_crc u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .packet_id (packet_id),
        .hdr_load  (hdr_load)
    );

    pkh_hdr u_hdr (
        .clk      (clk),
        .rst_n    (rst_n),
        .hdr_load (hdr_load),
        .status   (hdr_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
